@@ hw/rtl/dgcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dgcc_pkg;

  localparam int unsigned ADJ_W            = 64;
  localparam int unsigned CNT_W            = 4;
  localparam int unsigned ROW_STRIDE       = 8;
  localparam int unsigned SMALL_LIMIT      = 2;
  localparam int unsigned MAX_NODES_DEF    = 8;
  localparam int unsigned ROUNDS_PER_STAGE = 2;

endpackage

`default_nettype wire

@@ hw/rtl/dgcc_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dgcc_stage #(
  parameter int unsigned MAX_NODES = dgcc_pkg::MAX_NODES_DEF,
  parameter int unsigned ROUNDS    = dgcc_pkg::ROUNDS_PER_STAGE
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      up_valid,
  output logic                           up_ready,
  input  wire logic [MAX_NODES-1:0]      up_alive,
  input  wire logic [dgcc_pkg::ADJ_W-1:0] up_adj,
  output logic                           dn_valid,
  input  wire logic                      dn_ready,
  output logic [MAX_NODES-1:0]           dn_alive,
  output logic [dgcc_pkg::ADJ_W-1:0]     dn_adj
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [MAX_NODES-1:0]       alive_r;
  logic [MAX_NODES-1:0]       alive_nxt;
  logic [dgcc_pkg::ADJ_W-1:0] adj_r;
  logic                       load;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  // each round drops every node with no edge into the remaining set
  always_comb begin
    logic [MAX_NODES-1:0] cur;
    logic [MAX_NODES-1:0] sink;
    cur = up_alive;
    for (int r = 0; r < ROUNDS; r++) begin
      for (int n = 0; n < MAX_NODES; n++) begin
        sink[n] = cur[n] &&
                  ((up_adj[n*dgcc_pkg::ROW_STRIDE +: MAX_NODES] & cur) == '0);
      end
      cur = cur & ~sink;
    end
    alive_nxt = cur;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      alive_r <= alive_nxt;
      adj_r   <= up_adj;
    end
  end

  assign dn_valid = valid_r;
  assign dn_alive = alive_r;
  assign dn_adj   = adj_r;

endmodule

`default_nettype wire

@@ hw/rtl/directed_graph_cycle_check_unit.sv @@
// Directed graph cycle check.
// Input channel: in_valid/in_ready with in_adjacency (bit row*8+col marks an
// edge row->col) and in_node_count. Result channel: out_valid/out_ready with
// out_acyclic, 1 when the first node_count nodes hold no directed cycle.
// A self-loop is a cycle if the count exceeds 2; a count of 2 or less always
// reports acyclic; a count above MAX_NODES is taken as MAX_NODES.
// The check peels off all sink nodes in parallel, two rounds per stage, in
// a chain of ceil(MAX_NODES/2) register stages (4 for eight nodes). While
// out_ready is high one transaction enters every cycle, so the throughput
// is one result per cycle.
// Each stage holds its own valid bit; when out_ready is low the stages fill
// up and in_ready drops once every stage is occupied. Nothing is lost or
// repeated across a stall.
// Reset (rst_n low, synchronous) empties the pipeline; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module directed_graph_cycle_check_unit #(
  parameter int unsigned MAX_NODES = dgcc_pkg::MAX_NODES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [dgcc_pkg::ADJ_W-1:0] in_adjacency,
  input  wire logic [dgcc_pkg::CNT_W-1:0] in_node_count,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_acyclic
);

  localparam int unsigned NUM_STAGES =
    (MAX_NODES + dgcc_pkg::ROUNDS_PER_STAGE - 1) / dgcc_pkg::ROUNDS_PER_STAGE;

  logic                       valid_w [0:NUM_STAGES];
  logic                       ready_w [0:NUM_STAGES];
  logic [MAX_NODES-1:0]       alive_w [0:NUM_STAGES];
  logic [dgcc_pkg::ADJ_W-1:0] adj_w   [0:NUM_STAGES];

  logic [dgcc_pkg::CNT_W-1:0] cnt_sat;
  logic                       few_nodes;
  logic [MAX_NODES-1:0]       alive_init;

  assign few_nodes = in_node_count <= dgcc_pkg::CNT_W'(dgcc_pkg::SMALL_LIMIT);
  assign cnt_sat   = (in_node_count > dgcc_pkg::CNT_W'(MAX_NODES)) ?
                     dgcc_pkg::CNT_W'(MAX_NODES) : in_node_count;

  always_comb begin
    for (int n = 0; n < MAX_NODES; n++) begin
      alive_init[n] = !few_nodes && (dgcc_pkg::CNT_W'(n) < cnt_sat);
    end
  end

  assign alive_w[0] = alive_init;
  assign valid_w[0] = in_valid;
  assign adj_w[0]   = in_adjacency;
  assign in_ready   = ready_w[0];

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    dgcc_stage #(
      .MAX_NODES (MAX_NODES),
      .ROUNDS    (dgcc_pkg::ROUNDS_PER_STAGE)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid_w[s]),
      .up_ready (ready_w[s]),
      .up_alive (alive_w[s]),
      .up_adj   (adj_w[s]),
      .dn_valid (valid_w[s+1]),
      .dn_ready (ready_w[s+1]),
      .dn_alive (alive_w[s+1]),
      .dn_adj   (adj_w[s+1])
    );
  end

  assign ready_w[NUM_STAGES] = out_ready;
  assign out_valid           = valid_w[NUM_STAGES];
  assign out_acyclic         = (alive_w[NUM_STAGES] == '0);

endmodule

`default_nettype wire
